// ----- rtl/rpc_response_envelope_parser_macros.svh -----
// ----------------------------------------------------------------------------
// rpc response envelope parser assertion macros
// shared concurrent assertion forms, same-cycle and next-cycle
// ----------------------------------------------------------------------------
`ifndef RPC_RESPONSE_ENVELOPE_PARSER_MACROS_SVH
`define RPC_RESPONSE_ENVELOPE_PARSER_MACROS_SVH

// consequent checked in the same cycle
`define RREP_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define RREP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rrep_pkg.sv -----
// ----------------------------------------------------------------------------
// rrep_pkg
// types and constants of the rpc response envelope parser
// ----------------------------------------------------------------------------
package rrep_pkg;

    typedef enum logic [3:0] {
        PH_OTAG  = 4'd0,
        PH_OVAL  = 4'd1,
        PH_OLEN  = 4'd2,
        PH_OBODY = 4'd3,
        PH_ITAG  = 4'd4,
        PH_IVAL  = 4'd5,
        PH_ILEN  = 4'd6,
        PH_IBODY = 4'd7,
        PH_ISKIP = 4'd8
    } t_phase;

    localparam logic [1:0] KIND_MESSAGE = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_VARINT_LONG = 3'd1;
    localparam logic [2:0] ERR_WIRE_TYPE   = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
    localparam logic [2:0] ERR_TOO_LARGE   = 3'd4;

    localparam logic [1:0] OCLS_OTHER   = 2'd0;
    localparam logic [1:0] OCLS_STATUS  = 2'd1;
    localparam logic [1:0] OCLS_PAYLOAD = 2'd2;

    localparam logic [1:0] ICLS_OTHER    = 2'd0;
    localparam logic [1:0] ICLS_SELECTED = 2'd1;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_LEN    = 3'd2;

    localparam logic [31:0] FNUM_STATUS  = 32'd1;
    localparam logic [31:0] FNUM_PAYLOAD = 32'd2;
    localparam logic [31:0] FNUM_CODE    = 32'd1;
    localparam logic [31:0] FNUM_MESSAGE = 32'd2;

    localparam logic [3:0]  VARINT_MAX_BYTES  = 4'd10;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd4194304;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         out_byte;
        logic signed [31:0] status_code;
        logic               has_status;
        logic [2:0]         error_code;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push;

endpackage

// ----- rtl/rrep_if.sv -----
// ----------------------------------------------------------------------------
// rrep_if
// valid/ready channels for input bytes and parse results
// ----------------------------------------------------------------------------
interface rrep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_response;

    modport source (output valid, output data_byte, output end_of_response, input ready);
    modport sink (input valid, input data_byte, input end_of_response, output ready);
endinterface

interface rrep_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic signed [31:0] status_code;
    logic               has_status;
    logic [2:0]         error_code;
    logic               last_of_run;

    modport source (
        output valid, output kind, output out_byte, output status_code,
        output has_status, output error_code, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input status_code,
        input has_status, input error_code, input last_of_run, output ready
    );
endinterface

// ----- rtl/rrep_decoder.sv -----
// ----------------------------------------------------------------------------
// rrep_decoder
// per-byte wire format parse state and result generation
// ----------------------------------------------------------------------------
`include "rpc_response_envelope_parser_macros.svh"

module rrep_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end,
    input  logic                  i_cfg_wr_en,
    input  logic [31:0]           i_cfg_wr_data,
    output rrep_pkg::t_push       o_push
);

    rrep_pkg::t_phase r_phase, n_phase, s_phase;
    logic [63:0]      r_acc, n_acc, s_acc;
    logic [3:0]       r_vcnt, n_vcnt, s_vcnt;
    logic [1:0]       r_ocls, n_ocls, s_ocls;
    logic [1:0]       r_icls, n_icls, s_icls;
    logic [63:0]      r_fbl, n_fbl, s_fbl;
    logic [63:0]      r_sbl, n_sbl, s_sbl;
    logic [63:0]      r_ibl, n_ibl, s_ibl;
    logic             r_seen, n_seen, s_seen;
    logic [31:0]      r_sval, n_sval, s_sval;
    logic [2:0]       r_err, n_err, s_err;
    logic [31:0]      r_max;

    logic [5:0]       w_shamt;
    logic [63:0]      w_fed;
    logic             w_too_long;
    logic             w_vdone;
    logic             w_is_varint;
    logic [2:0]       w_wt;
    logic [31:0]      w_fnum;
    logic [63:0]      w_sbl_dec;
    logic [63:0]      w_fbl_dec;
    logic [63:0]      w_ibl_dec;
    logic             w_ret;
    logic             w_body_v;
    logic [2:0]       w_sum_err;
    rrep_pkg::t_result w_body;
    rrep_pkg::t_result w_sum;

    assign w_shamt    = 6'(r_vcnt) * 6'd7;
    assign w_fed      = r_acc | ({56'd0, 1'b0, i_data_byte[6:0]} << w_shamt);
    assign w_too_long = r_vcnt >= rrep_pkg::VARINT_MAX_BYTES;
    assign w_vdone    = !i_data_byte[7];
    assign w_wt       = w_fed[2:0];
    assign w_fnum     = w_fed[34:3];
    assign w_sbl_dec  = r_sbl - 64'd1;
    assign w_fbl_dec  = r_fbl - 64'd1;
    assign w_ibl_dec  = r_ibl - 64'd1;
    assign w_is_varint = (r_phase == rrep_pkg::PH_OTAG) || (r_phase == rrep_pkg::PH_OVAL)
                      || (r_phase == rrep_pkg::PH_OLEN) || (r_phase == rrep_pkg::PH_ITAG)
                      || (r_phase == rrep_pkg::PH_IVAL) || (r_phase == rrep_pkg::PH_ILEN);

    // effect of one byte on the parse state
    always_comb begin
        s_phase = r_phase;
        s_acc   = r_acc;
        s_vcnt  = r_vcnt;
        s_ocls  = r_ocls;
        s_icls  = r_icls;
        s_fbl   = r_fbl;
        s_sbl   = r_sbl;
        s_ibl   = r_ibl;
        s_seen  = r_seen;
        s_sval  = r_sval;
        s_err   = r_err;
        w_ret   = 1'b0;
        if (r_err == rrep_pkg::ERR_NONE) begin
            if (w_is_varint && !w_too_long) begin
                if (w_vdone) begin
                    s_acc  = 64'd0;
                    s_vcnt = 4'd0;
                end else begin
                    s_acc  = w_fed;
                    s_vcnt = r_vcnt + 4'd1;
                end
            end
            case (r_phase)
                rrep_pkg::PH_OTAG: begin
                    if (w_too_long) begin
                        s_err = rrep_pkg::ERR_VARINT_LONG;
                    end else if (w_vdone) begin
                        if (w_wt == rrep_pkg::WT_VARINT) begin
                            s_phase = rrep_pkg::PH_OVAL;
                        end else if (w_wt == rrep_pkg::WT_LEN) begin
                            s_ocls = (w_fnum == rrep_pkg::FNUM_STATUS) ? rrep_pkg::OCLS_STATUS :
                                     (w_fnum == rrep_pkg::FNUM_PAYLOAD) ? rrep_pkg::OCLS_PAYLOAD :
                                     rrep_pkg::OCLS_OTHER;
                            s_phase = rrep_pkg::PH_OLEN;
                        end else begin
                            s_err = rrep_pkg::ERR_WIRE_TYPE;
                        end
                    end
                end
                rrep_pkg::PH_OVAL: begin
                    if (w_too_long) begin
                        s_err = rrep_pkg::ERR_VARINT_LONG;
                    end else if (w_vdone) begin
                        s_phase = rrep_pkg::PH_OTAG;
                    end
                end
                rrep_pkg::PH_OLEN: begin
                    if (w_too_long) begin
                        s_err = rrep_pkg::ERR_VARINT_LONG;
                    end else if (w_vdone) begin
                        if (r_ocls == rrep_pkg::OCLS_STATUS) begin
                            s_seen = 1'b1;
                            if (w_fed == 64'd0) begin
                                s_phase = rrep_pkg::PH_OTAG;
                            end else begin
                                s_sbl   = w_fed;
                                s_phase = rrep_pkg::PH_ITAG;
                            end
                        end else if (r_ocls == rrep_pkg::OCLS_PAYLOAD
                                     && w_fed > {32'd0, r_max}) begin
                            s_err = rrep_pkg::ERR_TOO_LARGE;
                        end else if (w_fed == 64'd0) begin
                            s_phase = rrep_pkg::PH_OTAG;
                        end else begin
                            s_fbl   = w_fed;
                            s_phase = rrep_pkg::PH_OBODY;
                        end
                    end
                end
                rrep_pkg::PH_OBODY: begin
                    s_fbl = w_fbl_dec;
                    if (w_fbl_dec == 64'd0) begin
                        s_phase = rrep_pkg::PH_OTAG;
                    end
                end
                default: begin
                    s_sbl = w_sbl_dec;
                    case (r_phase)
                        rrep_pkg::PH_ITAG: begin
                            if (w_too_long) begin
                                s_err = rrep_pkg::ERR_VARINT_LONG;
                                w_ret = 1'b1;
                            end else if (w_vdone) begin
                                if (w_wt == rrep_pkg::WT_VARINT) begin
                                    s_icls  = (w_fnum == rrep_pkg::FNUM_CODE) ?
                                              rrep_pkg::ICLS_SELECTED : rrep_pkg::ICLS_OTHER;
                                    s_phase = rrep_pkg::PH_IVAL;
                                end else if (w_wt == rrep_pkg::WT_LEN) begin
                                    s_icls  = (w_fnum == rrep_pkg::FNUM_MESSAGE) ?
                                              rrep_pkg::ICLS_SELECTED : rrep_pkg::ICLS_OTHER;
                                    s_phase = rrep_pkg::PH_ILEN;
                                end else begin
                                    s_phase = rrep_pkg::PH_ISKIP;
                                end
                            end
                        end
                        rrep_pkg::PH_IVAL: begin
                            if (w_too_long) begin
                                s_err = rrep_pkg::ERR_VARINT_LONG;
                                w_ret = 1'b1;
                            end else if (w_vdone) begin
                                if (r_icls == rrep_pkg::ICLS_SELECTED) begin
                                    s_sval = w_fed[31:0];
                                end
                                s_phase = rrep_pkg::PH_ITAG;
                            end
                        end
                        rrep_pkg::PH_ILEN: begin
                            if (w_too_long) begin
                                s_err = rrep_pkg::ERR_VARINT_LONG;
                                w_ret = 1'b1;
                            end else if (w_vdone) begin
                                if (w_fed > w_sbl_dec) begin
                                    s_err = rrep_pkg::ERR_TRUNCATED;
                                    w_ret = 1'b1;
                                end else if (w_fed == 64'd0) begin
                                    s_phase = rrep_pkg::PH_ITAG;
                                end else begin
                                    s_ibl   = w_fed;
                                    s_phase = rrep_pkg::PH_IBODY;
                                end
                            end
                        end
                        rrep_pkg::PH_IBODY: begin
                            s_ibl = w_ibl_dec;
                            if (w_ibl_dec == 64'd0) begin
                                s_phase = rrep_pkg::PH_ITAG;
                            end
                        end
                        default: begin
                        end
                    endcase
                    // end of the status field
                    if (!w_ret && w_sbl_dec == 64'd0) begin
                        if ((s_phase == rrep_pkg::PH_ITAG && s_vcnt == 4'd0)
                            || s_phase == rrep_pkg::PH_ISKIP) begin
                            s_phase = rrep_pkg::PH_OTAG;
                        end else begin
                            s_err = rrep_pkg::ERR_TRUNCATED;
                        end
                    end
                end
            endcase
        end
    end

    // next state: hold, step, or clear after the final byte
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_vcnt  = r_vcnt;
        n_ocls  = r_ocls;
        n_icls  = r_icls;
        n_fbl   = r_fbl;
        n_sbl   = r_sbl;
        n_ibl   = r_ibl;
        n_seen  = r_seen;
        n_sval  = r_sval;
        n_err   = r_err;
        if (i_accept) begin
            if (i_end) begin
                n_phase = rrep_pkg::PH_OTAG;
                n_acc   = 64'd0;
                n_vcnt  = 4'd0;
                n_ocls  = rrep_pkg::OCLS_OTHER;
                n_icls  = rrep_pkg::ICLS_OTHER;
                n_fbl   = 64'd0;
                n_sbl   = 64'd0;
                n_ibl   = 64'd0;
                n_seen  = 1'b0;
                n_sval  = 32'd0;
                n_err   = rrep_pkg::ERR_NONE;
            end else begin
                n_phase = s_phase;
                n_acc   = s_acc;
                n_vcnt  = s_vcnt;
                n_ocls  = s_ocls;
                n_icls  = s_icls;
                n_fbl   = s_fbl;
                n_sbl   = s_sbl;
                n_ibl   = s_ibl;
                n_seen  = s_seen;
                n_sval  = s_sval;
                n_err   = s_err;
            end
        end
    end

    // result words
    always_comb begin
        w_body_v = (r_err == rrep_pkg::ERR_NONE)
                && ((r_phase == rrep_pkg::PH_OBODY && r_ocls == rrep_pkg::OCLS_PAYLOAD)
                 || (r_phase == rrep_pkg::PH_IBODY && r_icls == rrep_pkg::ICLS_SELECTED));
        w_sum_err = s_err;
        if (s_err == rrep_pkg::ERR_NONE
            && (s_phase != rrep_pkg::PH_OTAG || s_vcnt != 4'd0)) begin
            w_sum_err = rrep_pkg::ERR_TRUNCATED;
        end

        w_body.kind        = (r_phase == rrep_pkg::PH_OBODY) ?
                             rrep_pkg::KIND_PAYLOAD : rrep_pkg::KIND_MESSAGE;
        w_body.out_byte    = i_data_byte;
        w_body.status_code = r_sval;
        w_body.has_status  = r_seen;
        w_body.error_code  = r_err;
        w_body.last_of_run = !i_end;

        w_sum.kind         = rrep_pkg::KIND_SUMMARY;
        w_sum.out_byte     = 8'd0;
        w_sum.status_code  = s_sval;
        w_sum.has_status   = s_seen;
        w_sum.error_code   = w_sum_err;
        w_sum.last_of_run  = 1'b1;

        o_push.a_valid = i_accept && (w_body_v || i_end);
        o_push.a       = w_body_v ? w_body : w_sum;
        o_push.b_valid = i_accept && w_body_v && i_end;
        o_push.b       = w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rrep_pkg::PH_OTAG;
            r_acc   <= 64'd0;
            r_vcnt  <= 4'd0;
            r_ocls  <= rrep_pkg::OCLS_OTHER;
            r_icls  <= rrep_pkg::ICLS_OTHER;
            r_fbl   <= 64'd0;
            r_sbl   <= 64'd0;
            r_ibl   <= 64'd0;
            r_seen  <= 1'b0;
            r_sval  <= 32'd0;
            r_err   <= rrep_pkg::ERR_NONE;
            r_max   <= rrep_pkg::MAX_PAYLOAD_RESET;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_vcnt  <= n_vcnt;
            r_ocls  <= n_ocls;
            r_icls  <= n_icls;
            r_fbl   <= n_fbl;
            r_sbl   <= n_sbl;
            r_ibl   <= n_ibl;
            r_seen  <= n_seen;
            r_sval  <= n_sval;
            r_err   <= n_err;
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
        end
    end

    `RREP_ASSERT_HOLDS(a_vcnt_bound, i_clk, i_rst_n, 1'b1, r_vcnt <= rrep_pkg::VARINT_MAX_BYTES, "varint byte count past limit")
    `RREP_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_err != rrep_pkg::ERR_NONE && !(i_accept && i_end), r_err == $past(r_err), "error changed before end of response")
    `RREP_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_accept && i_end, r_phase == rrep_pkg::PH_OTAG && r_err == rrep_pkg::ERR_NONE && r_vcnt == 4'd0, "parse state not cleared after end")

endmodule

// ----- rtl/rrep_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rrep_out_fifo
// result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`include "rpc_response_envelope_parser_macros.svh"

module rrep_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrep_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    output rrep_pkg::t_result o_data,
    input  logic              i_pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rrep_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]     r_wr, n_wr;
    logic [PW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_count, n_count;
    logic [PW-1:0]     w_wr_next;
    logic              w_pop;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_wr_next = f_inc(r_wr);
    assign o_valid   = r_count != '0;
    assign o_data    = r_mem[r_rd];
    assign o_room    = r_count <= CW'(DEPTH - 2);
    assign w_pop     = o_valid && i_pop_ready;

    always_comb begin
        n_wr = r_wr;
        if (i_push.b_valid) begin
            n_wr = f_inc(w_wr_next);
        end else if (i_push.a_valid) begin
            n_wr = w_wr_next;
        end
        n_rd    = w_pop ? f_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push.a_valid) + CW'(i_push.b_valid) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[w_wr_next] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `RREP_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "queue count past depth")
    `RREP_ASSERT_HOLDS(a_push_room, i_clk, i_rst_n, i_push.a_valid, r_count <= CW'(DEPTH - 2), "push without room for two words")
    `RREP_ASSERT_HOLDS(a_push_order, i_clk, i_rst_n, i_push.b_valid, i_push.a_valid, "second word pushed without first")

endmodule

// ----- rtl/rpc_response_envelope_parser.sv -----
// a result word is written into the output queue when its input byte is accepted
// throughput: one byte per cycle while the output queue has room; a final
//   byte that also carries a message or payload byte yields two words at once
// the output queue accepts a byte only while it has room for two words
// reset: sync active low, clears parse state and queue, presets max payload limit
// ----------------------------------------------------------------------------
// rpc_response_envelope_parser
// byte-serial decoder of a protobuf response envelope with status and payload
// ----------------------------------------------------------------------------
module rpc_response_envelope_parser #(
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrep_in_if.sink     i_in,
    rrep_out_if.source  o_out,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    rrep_pkg::t_push   w_push;
    rrep_pkg::t_result w_head;
    logic              w_room;
    logic              w_accept;

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid && w_room;

    rrep_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_in.data_byte),
        .i_end         (i_in.end_of_response),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (w_push)
    );

    rrep_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_valid     (o_out.valid),
        .o_data      (w_head),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.kind        = w_head.kind;
    assign o_out.out_byte    = w_head.out_byte;
    assign o_out.status_code = w_head.status_code;
    assign o_out.has_status  = w_head.has_status;
    assign o_out.error_code  = w_head.error_code;
    assign o_out.last_of_run = w_head.last_of_run;

endmodule

// ----- tb/tb_rpc_response_envelope_parser.sv -----
// ----------------------------------------------------------------------------
// tb_rpc_response_envelope_parser
// self-checking bench: protobuf-style responses, well-formed and broken, are
// fed byte by byte under four idle and payload-limit settings; every output
// word is compared against an in-bench decoder of the same envelope format
// ----------------------------------------------------------------------------
module tb_rpc_response_envelope_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import rrep_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_BYTES  = 160;

    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_I32    = 3'd5;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    localparam int SEND_IDLE [4] = '{0, 50, 0, 27};
    localparam int RECV_STALL[4] = '{0, 0, 50, 27};

    class parse_scoreboard;
        typedef enum {VI_MORE, VI_DONE, VI_LONG} vi_step_e;

        t_result     pending_words[$];
        logic [31:0] payload_limit;
        t_phase      phase;
        logic [63:0] acc;
        int          acc_bytes;
        logic [1:0]  ocls;
        logic [1:0]  icls;
        logic [63:0] field_left;
        logic [63:0] status_left;
        logic [63:0] inner_left;
        logic        seen;
        logic [31:0] code;
        logic [2:0]  err;
        int          errors;
        int          n_bytes;
        int          n_responses;
        int          n_payload;
        int          n_message;
        int          n_summary;
        int          n_flagged;

        function new();
            payload_limit = MAX_PAYLOAD_RESET;
            clear_parse();
            errors      = 0;
            n_bytes     = 0;
            n_responses = 0;
            n_payload   = 0;
            n_message   = 0;
            n_summary   = 0;
            n_flagged   = 0;
        endfunction

        function void set_limit(logic [31:0] v);
            payload_limit = v;
        endfunction

        function void clear_parse();
            phase       = PH_OTAG;
            acc         = '0;
            acc_bytes   = 0;
            ocls        = OCLS_OTHER;
            icls        = ICLS_OTHER;
            field_left  = '0;
            status_left = '0;
            inner_left  = '0;
            seen        = 1'b0;
            code        = '0;
            err         = ERR_NONE;
        endfunction

        function vi_step_e feed_varint(logic [7:0] b);
            if (acc_bytes >= VARINT_MAX_BYTES) return VI_LONG;
            acc = acc | (64'(b[6:0]) << (7 * acc_bytes));
            acc_bytes++;
            return b[7] ? VI_MORE : VI_DONE;
        endfunction

        function logic [63:0] pop_varint();
            logic [63:0] v;
            v         = acc;
            acc       = '0;
            acc_bytes = 0;
            return v;
        endfunction

        function void add_word(logic [1:0] kind, logic [7:0] b);
            t_result r;
            r.kind        = kind;
            r.out_byte    = b;
            r.status_code = code;
            r.has_status  = seen;
            r.error_code  = err;
            r.last_of_run = 1'b0;
            pending_words.insert(pending_words.size(), r);
        endfunction

        function void status_byte(logic [7:0] b);
            vi_step_e    s;
            logic [63:0] v;
            status_left--;
            case (phase)
                PH_ITAG: begin
                    s = feed_varint(b);
                    if (s == VI_LONG) begin
                        err = ERR_VARINT_LONG;
                        return;
                    end
                    if (s == VI_DONE) begin
                        v = pop_varint();
                        if (v[2:0] == WT_VARINT) begin
                            icls  = (v[34:3] == FNUM_CODE) ? ICLS_SELECTED : ICLS_OTHER;
                            phase = PH_IVAL;
                        end else if (v[2:0] == WT_LEN) begin
                            icls  = (v[34:3] == FNUM_MESSAGE) ? ICLS_SELECTED : ICLS_OTHER;
                            phase = PH_ILEN;
                        end else begin
                            phase = PH_ISKIP;
                        end
                    end
                end
                PH_IVAL: begin
                    s = feed_varint(b);
                    if (s == VI_LONG) begin
                        err = ERR_VARINT_LONG;
                        return;
                    end
                    if (s == VI_DONE) begin
                        v = pop_varint();
                        if (icls == ICLS_SELECTED) code = v[31:0];
                        phase = PH_ITAG;
                    end
                end
                PH_ILEN: begin
                    s = feed_varint(b);
                    if (s == VI_LONG) begin
                        err = ERR_VARINT_LONG;
                        return;
                    end
                    if (s == VI_DONE) begin
                        v = pop_varint();
                        if (v > status_left) begin
                            err = ERR_TRUNCATED;
                            return;
                        end
                        if (v == 0) begin
                            phase = PH_ITAG;
                        end else begin
                            inner_left = v;
                            phase      = PH_IBODY;
                        end
                    end
                end
                PH_IBODY: begin
                    if (icls == ICLS_SELECTED) add_word(KIND_MESSAGE, b);
                    inner_left--;
                    if (inner_left == 0) phase = PH_ITAG;
                end
                default: ;
            endcase
            if (status_left == 0) begin
                if ((phase == PH_ITAG && acc_bytes == 0) || phase == PH_ISKIP) begin
                    phase = PH_OTAG;
                end else begin
                    err = ERR_TRUNCATED;
                end
            end
        endfunction

        function void outer_byte(logic [7:0] b);
            vi_step_e    s;
            logic [63:0] v;
            case (phase)
                PH_OTAG, PH_OVAL, PH_OLEN: begin
                    s = feed_varint(b);
                    if (s == VI_LONG) begin
                        err = ERR_VARINT_LONG;
                        return;
                    end
                    if (s != VI_DONE) return;
                    v = pop_varint();
                    if (phase == PH_OTAG) begin
                        if (v[2:0] == WT_VARINT) begin
                            phase = PH_OVAL;
                        end else if (v[2:0] == WT_LEN) begin
                            ocls  = (v[34:3] == FNUM_STATUS)  ? OCLS_STATUS :
                                    (v[34:3] == FNUM_PAYLOAD) ? OCLS_PAYLOAD : OCLS_OTHER;
                            phase = PH_OLEN;
                        end else begin
                            err = ERR_WIRE_TYPE;
                        end
                    end else if (phase == PH_OVAL) begin
                        phase = PH_OTAG;
                    end else if (ocls == OCLS_STATUS) begin
                        seen = 1'b1;
                        if (v == 0) begin
                            phase = PH_OTAG;
                        end else begin
                            status_left = v;
                            phase       = PH_ITAG;
                        end
                    end else if (ocls == OCLS_PAYLOAD && v > 64'(payload_limit)) begin
                        err = ERR_TOO_LARGE;
                    end else if (v == 0) begin
                        phase = PH_OTAG;
                    end else begin
                        field_left = v;
                        phase      = PH_OBODY;
                    end
                end
                PH_OBODY: begin
                    if (ocls == OCLS_PAYLOAD) add_word(KIND_PAYLOAD, b);
                    field_left--;
                    if (field_left == 0) phase = PH_OTAG;
                end
                default: status_byte(b);
            endcase
        endfunction

        function void decode_byte(logic [7:0] b, logic last);
            int      first;
            t_result r;
            first = pending_words.size();
            n_bytes++;
            if (err == ERR_NONE) outer_byte(b);
            if (last) begin
                n_responses++;
                if (err == ERR_NONE && (phase != PH_OTAG || acc_bytes != 0)) err = ERR_TRUNCATED;
                add_word(KIND_SUMMARY, 8'h00);
                clear_parse();
            end
            if (pending_words.size() > first) begin
                r             = pending_words.pop_back();
                r.last_of_run = 1'b1;
                pending_words.insert(pending_words.size(), r);
            end
        endfunction

        function void compare_field(string name, logic signed [63:0] want,
                                    logic signed [63:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending_words.size() == 0) begin
                errors++;
                $error("unexpected word: kind %0d, byte %0h", got.kind, got.out_byte);
                return;
            end
            want = pending_words.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("status_code", want.status_code, got.status_code);
            compare_field("has_status", want.has_status, got.has_status);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
            case (want.kind)
                KIND_MESSAGE: n_message++;
                KIND_PAYLOAD: n_payload++;
                default: begin
                    n_summary++;
                    if (want.error_code != ERR_NONE) n_flagged++;
                end
            endcase
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [31:0]     cfg_wr_data;
    logic [31:0]     cur_limit;
    logic [7:0]      msg_q[$];
    logic [7:0]      inner_q[$];
    int              send_idle;
    int              recv_stall;
    int              phase_bytes;
    int              cycles;
    parse_scoreboard sb;

    rrep_in_if  in_if();
    rrep_out_if out_if();

    rpc_response_envelope_parser uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void put_varint(ref logic [7:0] q[$], input logic [63:0] v);
        logic [63:0] rest;
        rest = v;
        do begin
            q.insert(q.size(), {rest > 64'h7F, rest[6:0]});
            rest = rest >> 7;
        end while (rest != 0);
    endfunction

    function automatic void put_tag(ref logic [7:0] q[$], input logic [63:0] fnum,
                                    input logic [2:0] wt);
        put_varint(q, {fnum[60:0], wt});
    endfunction

    function automatic void put_random(ref logic [7:0] q[$], input int n);
        repeat (n) q.insert(q.size(), 8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [2:0] bad_wt();
        case ($urandom_range(0, 5))
            0: return WT_I64;
            1: return WT_SGROUP;
            2: return WT_EGROUP;
            3: return WT_I32;
            4: return WT_RSVD6;
            default: return WT_RSVD7;
        endcase
    endfunction

    function automatic logic [63:0] rand_varint();
        case ($urandom_range(0, 4))
            0: return 64'($urandom_range(0, 127));
            1: return 64'($urandom_range(0, 16383));
            2: return 64'($urandom);
            3: return {32'hFFFF_FFFF, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // field number with low word as given; upper bits random on one call in eight
    function automatic logic [63:0] wide_fnum(logic [31:0] low);
        if ($urandom_range(0, 7) == 0) return {3'b000, 29'($urandom), low};
        return 64'(low);
    endfunction

    function automatic void wrap_status(logic [63:0] fnum);
        put_tag(msg_q, fnum, WT_LEN);
        put_varint(msg_q, 64'(inner_q.size()));
        msg_q = {msg_q, inner_q};
    endfunction

    function automatic void build_status();
        int n;
        inner_q = {};
        repeat ($urandom_range(0, 3)) begin
            n = $urandom_range(0, 6);
            case ($urandom_range(0, 4))
                0: begin
                    put_tag(inner_q, 64'(FNUM_CODE), WT_VARINT);
                    put_varint(inner_q, rand_varint());
                end
                1, 2: begin
                    put_tag(inner_q, 64'(FNUM_MESSAGE), WT_LEN);
                    put_varint(inner_q, 64'(n));
                    put_random(inner_q, n);
                end
                3: begin
                    put_tag(inner_q, 64'($urandom_range(3, 20)), WT_VARINT);
                    put_varint(inner_q, rand_varint());
                end
                default: begin
                    put_tag(inner_q, 64'($urandom_range(0, 20)), WT_LEN);
                    put_varint(inner_q, 64'(n));
                    put_random(inner_q, n);
                end
            endcase
        end
        n = $urandom_range(0, 3);
        case ($urandom_range(0, 11))
            0: begin
                put_tag(inner_q, 64'($urandom_range(0, 20)), bad_wt());
                put_random(inner_q, n);
            end
            1: begin
                // message length running past the status field
                put_tag(inner_q, 64'(FNUM_MESSAGE), WT_LEN);
                put_varint(inner_q, 64'(n + $urandom_range(1, 3)));
                put_random(inner_q, n);
            end
            2: begin
                // code varint cut off by the end of the status field
                put_tag(inner_q, 64'(FNUM_CODE), WT_VARINT);
                inner_q.insert(inner_q.size(), 8'h80 | 8'($urandom_range(0, 127)));
            end
            default: ;
        endcase
        wrap_status(wide_fnum(FNUM_STATUS));
    endfunction

    function automatic void build_payload();
        int          n;
        logic [63:0] len;
        n   = $urandom_range(0, 8);
        len = 64'(n);
        case ($urandom_range(0, 15))
            0: len = 64'(cur_limit) + 64'd1;
            1: len = {32'($urandom), 32'($urandom)};
            default: ;
        endcase
        put_tag(msg_q, wide_fnum(FNUM_PAYLOAD), WT_LEN);
        put_varint(msg_q, len);
        put_random(msg_q, n);
    endfunction

    function automatic void build_response();
        int n;
        msg_q = {};
        repeat ($urandom_range(1, 4)) begin
            n = $urandom_range(0, 5);
            case ($urandom_range(0, 5))
                0: begin
                    put_tag(msg_q, wide_fnum($urandom_range(0, 40)), WT_VARINT);
                    put_varint(msg_q, rand_varint());
                end
                1, 2: build_status();
                3, 4: build_payload();
                default: begin
                    put_tag(msg_q, 64'($urandom_range(3, 40)), WT_LEN);
                    put_varint(msg_q, 64'(n));
                    put_random(msg_q, n);
                end
            endcase
        end
        case ($urandom_range(0, 19))
            0: if (msg_q.size() > 1) msg_q = msg_q[0:$urandom_range(0, msg_q.size() - 2)];
            1: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
            2: begin
                put_tag(msg_q, 64'($urandom_range(0, 40)), bad_wt());
                put_random(msg_q, $urandom_range(0, 3));
            end
            3: begin
                repeat (10) msg_q.insert(msg_q.size(), 8'h80 | 8'($urandom_range(0, 127)));
                msg_q.insert(msg_q.size(), 8'($urandom_range(0, 255)));
            end
            4: begin
                msg_q = {};
                put_random(msg_q, $urandom_range(1, 8));
            end
            default: ;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_if.valid           <= 1'b1;
        in_if.data_byte       <= b;
        in_if.end_of_response <= last;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic send_response();
        for (int i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_limit = v;
        sb.set_limit(v);
    endtask

    always @(negedge clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
                sb.decode_byte(in_if.data_byte, in_if.end_of_response);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
                sb.check_word({out_if.kind, out_if.out_byte, out_if.status_code,
                               out_if.has_status, out_if.error_code, out_if.last_of_run});
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        sb                    = new();
        cycles                = 0;
        rst_n                 = 1'b0;
        in_if.valid           = 1'b0;
        in_if.data_byte       = 8'h00;
        in_if.end_of_response = 1'b0;
        out_if.ready          = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        cur_limit             = MAX_PAYLOAD_RESET;
        send_idle             = 0;
        recv_stall            = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bad outer wire type
        msg_q = {};
        put_tag(msg_q, 64'(FNUM_PAYLOAD), WT_SGROUP);
        send_response();
        // ends inside a varint field
        msg_q = {};
        put_tag(msg_q, 64'd5, WT_VARINT);
        send_response();
        // payload with byte extremes, last byte also ends the response
        msg_q = {};
        put_tag(msg_q, 64'(FNUM_PAYLOAD), WT_LEN);
        put_varint(msg_q, 64'd2);
        msg_q.insert(msg_q.size(), 8'h00);
        msg_q.insert(msg_q.size(), 8'hFF);
        send_response();
        // status with the most negative code
        inner_q = {};
        put_tag(inner_q, 64'(FNUM_CODE), WT_VARINT);
        put_varint(inner_q, 64'h8000_0000);
        msg_q = {};
        wrap_status(64'(FNUM_STATUS));
        send_response();
        // payload one over the default limit
        msg_q = {};
        put_tag(msg_q, 64'(FNUM_PAYLOAD), WT_LEN);
        put_varint(msg_q, 64'(MAX_PAYLOAD_RESET) + 64'd1);
        send_response();
        // eleven-byte tag varint
        msg_q = {};
        repeat (10) msg_q.insert(msg_q.size(), 8'h80);
        msg_q.insert(msg_q.size(), 8'h01);
        send_response();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_limit(32'hFFFF_FFFF);
                1: write_limit(32'h0000_0000);
                2: write_limit(32'($urandom_range(1, 8)));
                default: write_limit(MAX_PAYLOAD_RESET);
            endcase
            send_idle   = SEND_IDLE[p];
            recv_stall  = RECV_STALL[p];
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_response();
                phase_bytes += msg_q.size();
                send_response();
            end
        end
        drain();

        $display("ran %0d responses, %0d bytes, under four limit and idle settings",
                 sb.n_responses, sb.n_bytes);
        $display("checked %0d payload, %0d message and %0d summary words, %0d with an error",
                 sb.n_payload, sb.n_message, sb.n_summary, sb.n_flagged);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rrep_pkg.sv
rtl/rrep_if.sv
rtl/rrep_decoder.sv
rtl/rrep_out_fifo.sv
rtl/rpc_response_envelope_parser.sv
tb/tb_rpc_response_envelope_parser.sv
